// ===== hw/rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and helpers for the stream find-and-replace core
// Word formats, configuration register map, job descriptor handed from the
// match front end to the result sequencer, and small byte helpers.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Lengths come from 4-bit registers, so every length fits in four bits
    localparam int LEN_W     = 4;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_BYTES = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WHOLE_WORD = 3'd4;

    // Word character class bounds
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    typedef struct packed {
        logic [7:0] in_char;
        logic       line_end;
    } t_in_word;

    typedef struct packed {
        logic [7:0]       out_char;
        logic             out_line_end;
        logic             last;
        logic [CNT_W-1:0] replacements;
    } t_out_word;

    typedef struct packed {
        logic [63:0]      pattern;
        logic [63:0]      replace;
        logic [LEN_W-1:0] pat_len;
        logic [LEN_W-1:0] rep_len;
        logic             whole_word;
    } t_cfg;

    // One input's results: head (pending match resolved), prefix of the
    // window, one middle byte (the character or the line separator), tail
    typedef struct packed {
        logic             head_rep;
        logic [LEN_W-1:0] head_len;
        logic [LEN_W-1:0] pfx_len;
        logic             mid_en;
        logic             mid_sep;
        logic [7:0]       mid_char;
        logic             tail_rep;
        logic [LEN_W-1:0] tail_len;
        logic [CNT_W-1:0] count;
    } t_job;

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9));
    endfunction

    // Byte i of a 64-bit string register; bytes past the eighth read zero
    function automatic logic [7:0] byte_of(input logic [63:0] v, input logic [LEN_W-1:0] idx);
        logic [7:0] res;
        res = 8'h00;
        if (!idx[3]) begin
            res = v[{idx[2:0], 3'b000} +: 8];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/sfr_cell.sv =====
// ----------------------------------------------------------------------------
// sfr_cell: one stage of the partial-match chain
// Holds whether a partial match one byte longer than its left neighbor's is
// alive, and hands that flag to its right neighbor every cycle.
// ----------------------------------------------------------------------------
module sfr_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_char,
    input  logic [7:0] i_pat_byte,
    input  logic       i_flag,
    input  logic       i_shift,
    input  logic       i_clear,
    output logic       o_hit,
    output logic       o_flag
);

    logic r_flag;
    logic n_flag;

    // Extend the neighbor's partial match by the incoming character
    assign o_hit  = i_flag && (i_char == i_pat_byte);
    assign o_flag = r_flag;

    // Drop on a cut, advance on each accepted character
    always_comb begin
        n_flag = r_flag;
        if (i_clear) begin
            n_flag = 1'b0;
        end else if (i_shift) begin
            n_flag = o_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else begin
            r_flag <= n_flag;
        end
    end

endmodule

// ===== hw/rtl/sfr_emit.sv =====
// ----------------------------------------------------------------------------
// sfr_emit: result sequencer
// Holds one job descriptor and walks its segments into the output register
// at one word per unstalled cycle. Takes the next job as the last word leaves.
// ----------------------------------------------------------------------------
module sfr_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfr_pkg::t_cfg     i_cfg,
    input  sfr_pkg::t_job     i_job,
    input  logic              i_load,
    output logic              o_ready,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output sfr_pkg::t_out_word o_out_data
);

    import sfr_pkg::*;

    localparam logic [1:0] SEG_HEAD = 2'd0;
    localparam logic [1:0] SEG_PFX  = 2'd1;
    localparam logic [1:0] SEG_MID  = 2'd2;
    localparam logic [1:0] SEG_TAIL = 2'd3;
    localparam int         SEG_N    = 4;

    t_job             r_job;
    logic             r_vld;
    logic [1:0]       r_seg;
    logic [LEN_W-1:0] r_idx;
    t_out_word        r_out;
    logic             r_out_vld;

    logic [SEG_N-1:0] w_ne_in;
    logic [SEG_N-1:0] w_ne_cur;
    logic [1:0]       w_first;
    logic [1:0]       w_next;
    logic             w_has_next;
    logic [LEN_W-1:0] w_cur_len;
    logic             w_seg_end;
    logic             w_cur_last;
    logic [7:0]       w_byte;
    logic             w_out_load;
    logic             w_step;

    // Nonempty segments of the incoming and the current job
    always_comb begin
        w_ne_in[SEG_HEAD]  = (i_job.head_len != '0);
        w_ne_in[SEG_PFX]   = (i_job.pfx_len != '0);
        w_ne_in[SEG_MID]   = i_job.mid_en;
        w_ne_in[SEG_TAIL]  = (i_job.tail_len != '0);
        w_ne_cur[SEG_HEAD] = (r_job.head_len != '0);
        w_ne_cur[SEG_PFX]  = (r_job.pfx_len != '0);
        w_ne_cur[SEG_MID]  = r_job.mid_en;
        w_ne_cur[SEG_TAIL] = (r_job.tail_len != '0);
    end

    // Pick the first segment of a new job and the one after the current
    always_comb begin
        w_first    = SEG_HEAD;
        w_next     = SEG_HEAD;
        w_has_next = 1'b0;
        for (int s = SEG_N - 1; s >= 0; s--) begin
            if (w_ne_in[s]) begin
                w_first = 2'(s);
            end
            if (w_ne_cur[s] && (2'(s) > r_seg)) begin
                w_next     = 2'(s);
                w_has_next = 1'b1;
            end
        end
    end

    // Select the current byte and segment length
    always_comb begin
        unique case (r_seg)
            SEG_HEAD: begin
                w_cur_len = r_job.head_len;
                w_byte    = r_job.head_rep ? byte_of(i_cfg.replace, r_idx)
                                           : byte_of(i_cfg.pattern, r_idx);
            end
            SEG_PFX: begin
                w_cur_len = r_job.pfx_len;
                w_byte    = byte_of(i_cfg.pattern, r_idx);
            end
            SEG_MID: begin
                w_cur_len = {{(LEN_W-1){1'b0}}, r_job.mid_en};
                w_byte    = r_job.mid_sep ? 8'h00 : r_job.mid_char;
            end
            default: begin
                w_cur_len = r_job.tail_len;
                w_byte    = r_job.tail_rep ? byte_of(i_cfg.replace, r_idx)
                                           : byte_of(i_cfg.pattern, r_idx);
            end
        endcase
    end

    assign w_seg_end  = (r_idx == w_cur_len - 4'd1);
    assign w_cur_last = w_seg_end && !w_has_next;
    assign w_out_load = !r_out_vld || !i_out_stall;
    assign w_step     = r_vld && w_out_load;
    assign o_ready    = !r_vld || (w_step && w_cur_last);

    // Control: job occupancy, segment walk, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_seg     <= SEG_HEAD;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_vld <= r_vld;
            end
            if (i_load) begin
                r_vld <= 1'b1;
                r_seg <= w_first;
                r_idx <= '0;
            end else if (w_step) begin
                if (w_cur_last) begin
                    r_vld <= 1'b0;
                end
                if (w_seg_end) begin
                    r_seg <= w_next;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
        end
    end

    // Payload: hold the job, load the output word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
        if (w_step) begin
            r_out.out_char     <= w_byte;
            r_out.out_line_end <= (r_seg == SEG_MID) && r_job.mid_sep;
            r_out.last         <= w_cur_last;
            r_out.replacements <= r_job.count;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/stream_find_replace_core.sv =====
// ----------------------------------------------------------------------------
// stream_find_replace_core: streaming find-and-replace over text lines
// Input words carry one text byte or a line end; output words carry one byte
// or the line separator, a last flag and the running replacement count.
// Input and output channels use valid/stall; a word moves at a rising edge
// with valid high and stall low. The configuration channel (valid/ready,
// register index and 64-bit data) is always ready; write it only while the
// core is idle. A write of a listed register drops any pending characters.
// A chain of match cells tracks every live partial match; a job register
// and an output register sit behind it.
// The job register takes an input's job; its first result then goes to
// the output register. Throughput: one input per cycle while each input
// yields at most one result and the receiver does not stall; more results
// keep the result sequencer busy and the next input stalls until the last
// is loaded. An input that only extends a pending match yields no word.
// Reset (synchronous, active low) restores the register defaults, empties
// the window and clears the count. When the receiver stalls, the output
// word holds and the input side stalls once the job register is full.
// ----------------------------------------------------------------------------
module stream_find_replace_core #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  sfr_pkg::t_in_word                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output sfr_pkg::t_out_word                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [63:0]                        i_cfg_data
);

    import sfr_pkg::*;

    t_cfg             r_cfg;
    logic [LEN_W-1:0] r_fill;
    logic             r_await;
    logic [7:0]       r_prev;
    logic             r_start;
    logic [CNT_W-1:0] r_count;

    logic [LEN_W-1:0] n_fill;
    logic             n_await;
    logic [7:0]       n_prev;
    logic             n_start;
    logic [CNT_W-1:0] n_count;

    logic             w_in_acc;
    logic             w_cfg_wr;
    logic             w_cfg_hit;
    logic             w_emit_ready;
    logic             w_le;
    logic [7:0]       w_c;
    logic             w_ww;
    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] w_rlen;
    logic [LEN_W-1:0] w_fill_eff;
    logic             w_res_rep;
    logic [LEN_W-1:0] w_nf;
    logic [LEN_W-1:0] w_pfx_len;
    logic             w_match;
    logic [7:0]       w_prev_h;
    logic             w_start_h;
    logic [7:0]       w_prev_p;
    logic             w_start_p;
    logic             w_start_ok;
    logic             w_inc;
    logic             w_clear;
    logic             w_shift;
    logic             w_job_load;
    t_job             w_job;

    logic [MAX_PATTERN-1:0] w_hit;
    logic [MAX_PATTERN-1:0] w_flag;
    logic [7:0]             w_pat [MAX_PATTERN];

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = !w_emit_ready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_le        = i_in_data.line_end;
    assign w_c         = i_in_data.in_char;
    assign w_ww        = r_cfg.whole_word;

    // Configuration registers; a write of a listed register drops the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern    <= '0;
            r_cfg.pat_len    <= 4'd1;
            r_cfg.replace    <= '0;
            r_cfg.rep_len    <= '0;
            r_cfg.whole_word <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                REG_PATTERN:    r_cfg.pattern    <= i_cfg_data;
                REG_PAT_LEN:    r_cfg.pat_len    <= i_cfg_data[LEN_W-1:0];
                REG_REPLACE:    r_cfg.replace    <= i_cfg_data;
                REG_REP_LEN:    r_cfg.rep_len    <= i_cfg_data[LEN_W-1:0];
                REG_WHOLE_WORD: r_cfg.whole_word <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Listed registers occupy the lowest indexes
    assign w_cfg_hit = w_cfg_wr && (i_cfg_index <= REG_WHOLE_WORD);

    // Effective lengths: pattern at least one, both clipped to the maximum
    always_comb begin
        w_len = r_cfg.pat_len;
        if (r_cfg.pat_len == '0) begin
            w_len = 4'd1;
        end else if (32'(r_cfg.pat_len) > MAX_PATTERN) begin
            w_len = LEN_W'(MAX_PATTERN);
        end
        w_rlen = r_cfg.rep_len;
        if (32'(r_cfg.rep_len) > MAX_REPLACEMENT) begin
            w_rlen = LEN_W'(MAX_REPLACEMENT);
        end
    end

    // Partial-match chain: cell k extends a live match of length k
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_chain
        logic w_flag_in;
        if (k == 0) begin : g_head
            assign w_flag_in = 1'b1;
        end else begin : g_link
            assign w_flag_in = w_flag[k-1];
        end
        if (k < CFG_BYTES) begin : g_byte
            assign w_pat[k] = r_cfg.pattern[8*k +: 8];
        end else begin : g_zero
            assign w_pat[k] = 8'h00;
        end
        sfr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_char     (w_c),
            .i_pat_byte (w_pat[k]),
            .i_flag     (w_flag_in),
            .i_shift    (w_shift),
            .i_clear    (w_clear),
            .o_hit      (w_hit[k]),
            .o_flag     (w_flag[k])
        );
    end

    // New window fill: longest live match after this character
    always_comb begin
        w_nf = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (w_hit[k]) begin
                w_nf = LEN_W'(k + 1);
            end
        end
    end

    // A pending match resolves first and leaves the window empty
    assign w_fill_eff = r_await ? '0 : r_fill;
    assign w_res_rep  = w_le || !is_word(w_c);
    assign w_pfx_len  = (w_le || (w_nf == '0)) ? w_fill_eff : (w_fill_eff + 4'd1 - w_nf);
    assign w_match    = !w_le && (w_nf == w_len);

    // Last emitted character after the head, then after the window prefix
    always_comb begin
        w_prev_h  = r_prev;
        w_start_h = r_start;
        if (r_await && w_res_rep && (w_rlen != '0)) begin
            w_prev_h  = byte_of(r_cfg.replace, w_rlen - 4'd1);
            w_start_h = 1'b0;
        end else if (r_await && !w_res_rep) begin
            w_prev_h  = byte_of(r_cfg.pattern, w_len - 4'd1);
            w_start_h = 1'b0;
        end
        w_prev_p  = w_prev_h;
        w_start_p = w_start_h;
        if (w_pfx_len != '0) begin
            w_prev_p  = byte_of(r_cfg.pattern, w_pfx_len - 4'd1);
            w_start_p = 1'b0;
        end
    end

    assign w_start_ok = w_start_p || !is_word(w_prev_p);
    // At most one replacement per input: a resolved pending match only
    // exists in whole-word mode, where a fresh match waits instead
    assign w_inc      = (r_await && w_res_rep) || (w_match && !w_ww);

    // Build the job for this input
    always_comb begin
        w_job.head_rep = w_res_rep;
        w_job.head_len = r_await ? (w_res_rep ? w_rlen : w_len) : '0;
        w_job.pfx_len  = w_pfx_len;
        w_job.mid_en   = w_le || (w_nf == '0);
        w_job.mid_sep  = w_le;
        w_job.mid_char = w_c;
        w_job.tail_rep = !w_ww;
        w_job.tail_len = '0;
        if (w_match) begin
            if (!w_ww) begin
                w_job.tail_len = w_rlen;
            end else if (!w_start_ok) begin
                w_job.tail_len = w_len;
            end
        end
        w_job.count = n_count;
    end

    assign w_job_load = w_in_acc && ((w_job.head_len != '0) || (w_job.pfx_len != '0) ||
                                     w_job.mid_en || (w_job.tail_len != '0));

    // Next state of the window and the line context
    always_comb begin
        n_fill  = r_fill;
        n_await = r_await;
        n_prev  = r_prev;
        n_start = r_start;
        n_count = r_count;
        w_clear = 1'b0;
        w_shift = 1'b0;
        if (w_in_acc) begin
            n_fill  = '0;
            n_await = 1'b0;
            if (w_inc && (r_count != '1)) begin
                n_count = r_count + 32'd1;
            end
            if (w_le) begin
                n_prev  = 8'h00;
                n_start = 1'b1;
                w_clear = 1'b1;
            end else if (w_nf == '0) begin
                n_prev  = w_c;
                n_start = 1'b0;
                w_shift = 1'b1;
            end else if (w_match) begin
                w_clear = 1'b1;
                n_prev  = w_prev_p;
                n_start = w_start_p;
                if (!w_ww) begin
                    if (w_rlen != '0) begin
                        n_prev  = byte_of(r_cfg.replace, w_rlen - 4'd1);
                        n_start = 1'b0;
                    end
                end else if (w_start_ok) begin
                    n_await = 1'b1;
                    n_fill  = w_len;
                end else begin
                    n_prev  = byte_of(r_cfg.pattern, w_len - 4'd1);
                    n_start = 1'b0;
                end
            end else begin
                n_fill  = w_nf;
                n_prev  = w_prev_p;
                n_start = w_start_p;
                w_shift = 1'b1;
            end
        end
        if (w_cfg_hit) begin
            n_fill  = '0;
            n_await = 1'b0;
            w_clear = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_await <= 1'b0;
            r_prev  <= 8'h00;
            r_start <= 1'b1;
            r_count <= '0;
        end else begin
            r_fill  <= n_fill;
            r_await <= n_await;
            r_prev  <= n_prev;
            r_start <= n_start;
            r_count <= n_count;
        end
    end

    // Result sequencer and output register
    sfr_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (w_job),
        .i_load      (w_job_load),
        .o_ready     (w_emit_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
